// ===== hw/rtl/serial_rgb_led_fader_top_assert.svh =====
// ----------------------------------------------------------------------------
// serial_rgb_led_fader_top_assert.svh
// Assertion macros shared by the RGB LED fader RTL.
// ----------------------------------------------------------------------------
`ifndef SERIAL_RGB_LED_FADER_TOP_ASSERT_SVH
`define SERIAL_RGB_LED_FADER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define SRLF_ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// consequent must hold in the cycle after the antecedent
`define SRLF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SRLF_ASSERT_ALWAYS(lbl, clk, rst, prop, msg)
`define SRLF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/srlf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srlf_pkg
// Types, character codes and colour table for the RGB LED fader.
// ----------------------------------------------------------------------------
package srlf_pkg;

   // item kinds
   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   // characters
   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_ZERO  = 8'd48;
   localparam logic [7:0] CH_R_UP  = 8'h52;
   localparam logic [7:0] CH_R_LO  = 8'h72;
   localparam logic [7:0] CH_G_UP  = 8'h47;
   localparam logic [7:0] CH_G_LO  = 8'h67;
   localparam logic [7:0] CH_B_UP  = 8'h42;
   localparam logic [7:0] CH_B_LO  = 8'h62;
   localparam logic [7:0] CH_D_UP  = 8'h44;
   localparam logic [7:0] CH_D_LO  = 8'h64;

   localparam logic [7:0] DIGIT_SCALE = 8'd10;
   localparam logic [7:0] PEAK_RESET  = 8'd100;
   localparam logic [7:0] LEVEL_MAX   = 8'd255;
   localparam logic [2:0] HUE_COUNT   = 3'd7;
   localparam logic [2:0] HUE_LAST    = 3'd6;

   // duty channel slots
   localparam int DUTY_RED   = 0;
   localparam int DUTY_GREEN = 1;
   localparam int DUTY_BLUE  = 2;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_RED,
      OP_GREEN,
      OP_BLUE,
      OP_DEMO
   } cmd_op_type;

   typedef struct packed {
      logic       exec;
      cmd_op_type op;
      logic [7:0] value;
   } cmd_type;

   // colour mix per hue slot: bit0 red, bit1 green, bit2 blue
   function automatic logic [2:0] hue_mix(input logic [2:0] slot);
      logic [2:0] mix;
      case (slot)
         3'd0:    mix = 3'b001;
         3'd1:    mix = 3'b010;
         3'd2:    mix = 3'b100;
         3'd3:    mix = 3'b011;
         3'd4:    mix = 3'b110;
         3'd5:    mix = 3'b101;
         default: mix = 3'b111;
      endcase
      return mix;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/srlf_cmd.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "serial_rgb_led_fader_top_assert.svh"
// ----------------------------------------------------------------------------
// srlf_cmd
// Command store, fill count and command decode on carriage return.
// ----------------------------------------------------------------------------
module srlf_cmd #(
   parameter int CMD_DEPTH = 6
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step,
   input  wire logic [7:0]       rx_byte,
   output srlf_pkg::cmd_type     cmd
);
   import srlf_pkg::*;

   localparam int FILL_W = $clog2(CMD_DEPTH + 1);
   localparam int IDX_W  = $clog2(CMD_DEPTH);

   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [7:0]        store_ff [CMD_DEPTH];
   logic [7:0]        view [3];
   logic [IDX_W-1:0]  wr_idx;
   logic              is_cr, has_room;
   logic [7:0]        d1, d2;

   assign is_cr    = (rx_byte == CH_CR);
   assign has_room = (fill_ff < FILL_W'(CMD_DEPTH));
   assign wr_idx   = fill_ff[IDX_W-1:0];

   always_comb begin
      fill_in = fill_ff;
      if (step) begin
         if (is_cr) begin
            fill_in = '0;
         end else if (has_room) begin
            fill_in = fill_ff + FILL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         for (int i = 0; i < CMD_DEPTH; i++) begin
            store_ff[i] <= '0;
         end
      end else begin
         fill_ff <= fill_in;
         if (step && has_room) begin
            store_ff[wr_idx] <= is_cr ? 8'd0 : rx_byte;
         end
      end
   end

   // first three entries as seen after the terminating zero is written
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         view[i] = (fill_ff == FILL_W'(i)) ? 8'd0 : store_ff[i];
      end
   end

   assign d1 = view[1] - CH_ZERO;
   assign d2 = view[2] - CH_ZERO;

   always_comb begin
      cmd.exec  = step && is_cr;
      cmd.value = 8'(d1 * DIGIT_SCALE) + d2;
      unique case (view[0]) inside
         CH_R_UP, CH_R_LO: cmd.op = OP_RED;
         CH_G_UP, CH_G_LO: cmd.op = OP_GREEN;
         CH_B_UP, CH_B_LO: cmd.op = OP_BLUE;
         CH_D_UP, CH_D_LO: cmd.op = OP_DEMO;
         default:          cmd.op = OP_NONE;
      endcase
   end

   `SRLF_ASSERT_ALWAYS(a_fill_bound, clock, reset, fill_ff <= FILL_W'(CMD_DEPTH), "fill past store")

endmodule
`default_nettype wire

// ===== hw/rtl/srlf_fade.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "serial_rgb_led_fader_top_assert.svh"
// ----------------------------------------------------------------------------
// srlf_fade
// Demo mode flag, fade level and hue, and the three duty registers.
// ----------------------------------------------------------------------------
module srlf_fade (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              tick,
   input  wire srlf_pkg::cmd_type cmd,
   input  wire logic [7:0]        fade_peak,
   output logic [7:0]             red_duty,
   output logic [7:0]             green_duty,
   output logic [7:0]             blue_duty,
   output logic                   demo_active
);
   import srlf_pkg::*;

   logic       demo_ff, demo_in;
   logic [7:0] level_ff, level_in;
   logic       rising_ff, rising_in;
   logic [2:0] hue_ff, hue_in;
   logic [7:0] duty_ff [3];
   logic [7:0] duty_in [3];
   logic [2:0] mix;

   always_comb begin
      demo_in   = demo_ff;
      level_in  = level_ff;
      rising_in = rising_ff;
      hue_in    = hue_ff;
      duty_in   = duty_ff;
      mix       = hue_mix(hue_ff);
      if (cmd.exec) begin
         if (demo_ff) begin
            if (cmd.op == OP_DEMO) begin
               demo_in   = 1'b0;
               level_in  = '0;
               rising_in = 1'b1;
               hue_in    = '0;
               for (int k = 0; k < 3; k++) begin
                  duty_in[k] = '0;
               end
            end
         end else begin
            case (cmd.op)
               OP_RED:   duty_in[DUTY_RED]   = cmd.value;
               OP_GREEN: duty_in[DUTY_GREEN] = cmd.value;
               OP_BLUE:  duty_in[DUTY_BLUE]  = cmd.value;
               OP_DEMO:  demo_in             = 1'b1;
               default:  ;
            endcase
         end
      end else if (tick && demo_ff) begin
         if (rising_ff) begin
            level_in = (level_ff != LEVEL_MAX) ? level_ff + 8'd1 : level_ff;
            if (level_in >= fade_peak) begin
               rising_in = 1'b0;
            end
         end else begin
            level_in = (level_ff != 8'd0) ? level_ff - 8'd1 : 8'd0;
            if (level_in == 8'd0) begin
               rising_in = 1'b1;
               hue_in    = (hue_ff == HUE_LAST) ? 3'd0 : hue_ff + 3'd1;
            end
         end
         mix = hue_mix(hue_in);
         for (int k = 0; k < 3; k++) begin
            duty_in[k] = mix[k] ? level_in : 8'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         demo_ff   <= 1'b0;
         level_ff  <= '0;
         rising_ff <= 1'b1;
         hue_ff    <= '0;
         for (int k = 0; k < 3; k++) begin
            duty_ff[k] <= '0;
         end
      end else begin
         demo_ff   <= demo_in;
         level_ff  <= level_in;
         rising_ff <= rising_in;
         hue_ff    <= hue_in;
         duty_ff   <= duty_in;
      end
   end

   assign red_duty    = duty_ff[DUTY_RED];
   assign green_duty  = duty_ff[DUTY_GREEN];
   assign blue_duty   = duty_ff[DUTY_BLUE];
   assign demo_active = demo_ff;

   // fade state is parked whenever demo mode is off
   `SRLF_ASSERT_ALWAYS(a_idle_fade, clock, reset, demo_ff || (level_ff == 8'd0 && rising_ff && hue_ff == 3'd0), "fade state not parked")
   `SRLF_ASSERT_ALWAYS(a_hue_range, clock, reset, hue_ff < HUE_COUNT, "hue slot out of range")

endmodule
`default_nettype wire

// ===== hw/rtl/serial_rgb_led_fader_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "serial_rgb_led_fader_top_assert.svh"
// An item accepted into the input register shows its result once it moves on to the result slot.
// Throughput: one item per cycle while rsp_stall is low; the input register refills while the result waits.
// Each item passes input register -> command/fade logic -> state and result registers.
// Reset (synchronous, active high) clears the pipeline, command store, fade state,
// duties and demo flag, and loads fade_peak with 100.
// ----------------------------------------------------------------------------
// serial_rgb_led_fader_top
// Serial command RGB LED duty controller with an automatic colour fade demo.
// ----------------------------------------------------------------------------
module serial_rgb_led_fader_top #(
   parameter int CMD_DEPTH = 6
) (
   input  wire logic       clock,
   input  wire logic       reset,
   // input items
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic       req_kind,
   input  wire logic [7:0] req_rx_byte,
   // result items
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_red_duty,
   output logic [7:0]      rsp_green_duty,
   output logic [7:0]      rsp_blue_duty,
   output logic            rsp_demo_active,
   output logic            rsp_echo_valid,
   output logic [7:0]      rsp_echo_byte,
   // fade_peak register
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [7:0] csr_data
);
   import srlf_pkg::*;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic       in_kind_ff;
   logic [7:0] in_byte_ff;

   // result register (duties and demo flag live in the fade unit)
   logic       out_valid_ff, out_valid_in;
   logic       echo_valid_ff;
   logic [7:0] echo_byte_ff;

   logic [7:0] fade_peak_ff;

   logic       req_take, out_free, advance;
   logic       cmd_step, fade_tick;
   cmd_type    cmd;

   // The result slot can be loaded when empty or being emptied this cycle.
   // State only moves on together with the result slot, so a stalled result
   // keeps showing the state as that item left it.
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign cmd_step  = advance && (in_kind_ff == KIND_BYTE);
   assign fade_tick = advance && (in_kind_ff == KIND_TICK);

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (out_free) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_kind_ff <= req_kind;
         in_byte_ff <= req_rx_byte;
      end
      if (advance) begin
         echo_valid_ff <= (in_kind_ff == KIND_BYTE);
         echo_byte_ff  <= (in_kind_ff == KIND_BYTE) ? in_byte_ff : 8'd0;
      end
   end

   // configuration: always ready; to be written only while idle, which the block does not enforce
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fade_peak_ff <= PEAK_RESET;
      end else if (csr_valid && csr_ready) begin
         fade_peak_ff <= csr_data;
      end
   end

   // command collection and decode
   srlf_cmd #(
      .CMD_DEPTH (CMD_DEPTH)
   ) u_cmd (
      .clock   (clock),
      .reset   (reset),
      .step    (cmd_step),
      .rx_byte (in_byte_ff),
      .cmd     (cmd)
   );

   // demo fade and duty registers
   srlf_fade u_fade (
      .clock       (clock),
      .reset       (reset),
      .tick        (fade_tick),
      .cmd         (cmd),
      .fade_peak   (fade_peak_ff),
      .red_duty    (rsp_red_duty),
      .green_duty  (rsp_green_duty),
      .blue_duty   (rsp_blue_duty),
      .demo_active (rsp_demo_active)
   );

   assign rsp_valid      = out_valid_ff;
   assign rsp_echo_valid = echo_valid_ff;
   assign rsp_echo_byte  = echo_byte_ff;

   // an item leaving the input register always lands in the result slot
   `SRLF_ASSERT_NEXT(a_advance_lands, clock, reset, advance, out_valid_ff, "item lost in transfer")
   // an item never passes the input register while the result slot is held
   `SRLF_ASSERT_ALWAYS(a_no_overrun, clock, reset, !(advance && out_valid_ff && rsp_stall), "result overrun")

endmodule
`default_nettype wire
